FILE: design/audio_flanger_defines.svh
// ----------------------------------------------------------------------------
// audio_flanger_defines
// assertion macros shared by the flanger checker
// ----------------------------------------------------------------------------
`ifndef AUDIO_FLANGER_DEFINES_SVH
`define AUDIO_FLANGER_DEFINES_SVH

// pre on one edge implies post on the next edge
`define AF_CHECK_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("flanger check failed");

// sig holds its value across the next edge while cond is seen
`define AF_CHECK_HOLD(name, cond, sig) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error("flanger hold check failed");

`endif

FILE: design/af_pkg.sv
// ----------------------------------------------------------------------------
// af_pkg
// shared types and constants of the flanger
// ----------------------------------------------------------------------------
`default_nettype none

package af_pkg;

  // sizes must be powers of two
  localparam int DELAY_DEPTH_DEF = 4096;
  localparam int SINE_SIZE_DEF   = 256;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 15;
  localparam int DLY_W    = 12;
  localparam int STEP_W   = 32;
  localparam int PHASE_W  = 32;
  localparam int IDX_W    = 4;
  localparam int DATA_W   = 32;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;

  localparam logic [IDX_W-1:0] REG_GAIN  = 4'd0;
  localparam logic [IDX_W-1:0] REG_MEAN  = 4'd1;
  localparam logic [IDX_W-1:0] REG_DEPTH = 4'd2;
  localparam logic [IDX_W-1:0] REG_STEP  = 4'd3;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 15'd29491;
  localparam logic [DLY_W-1:0]  MEAN_RST  = 12'd48;
  localparam logic [DLY_W-1:0]  DEPTH_RST = 12'd38;
  localparam logic [STEP_W-1:0] STEP_RST  = 32'd8948;

  // sine polynomial coefficients, q15
  localparam logic [MUL_W-1:0] SIN_A = 18'd51472;
  localparam logic [MUL_W-1:0] SIN_B = 18'd21167;
  localparam logic [MUL_W-1:0] SIN_C = 18'd2611;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

FILE: design/af_ram.sv
// ----------------------------------------------------------------------------
// af_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module af_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/af_mul.sv
// ----------------------------------------------------------------------------
// af_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module af_mul (
  input  wire logic                          clk,
  input  wire af_pkg::mul_req_t              req,
  output      logic signed [af_pkg::PROD_W-1:0] prod
);

  import af_pkg::*;

  // product holds while no step is issued
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule

`default_nettype wire

FILE: design/audio_flanger.sv
// ----------------------------------------------------------------------------
// audio_flanger
// feed-forward flanger: circular delay line read at an lfo-modulated offset
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  input    | in_valid / in_stall   | sample_in, channel
//  output   | out_valid / out_stall | sample_out
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  a right word passes straight into the output register when it is accepted
//  a left word passes accept, six steps of the shared 18x18 multiplier (sine
//  polynomial, depth scaling, then gain after one delay line read), one output load
//  the delay line needs no clearing after reset: a fill count marks unwritten
//  entries, which read as zero
//  a held output word stalls the input side; the last step waits for it too
// ----------------------------------------------------------------------------
`default_nettype none

module audio_flanger #(
  parameter int DELAY_DEPTH = af_pkg::DELAY_DEPTH_DEF,
  parameter int SINE_SIZE   = af_pkg::SINE_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic signed [af_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                          channel,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [af_pkg::SAMPLE_W-1:0] sample_out,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [af_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [af_pkg::DATA_W-1:0]     cfg_data
);

  import af_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SB = $clog2(SINE_SIZE);
  localparam logic [PHASE_W-1:0] PHASE_MASK = ~((PHASE_W'(1) << (PHASE_W - SB)) - 1'b1);
  localparam logic [21:0] DMAX = 22'(DELAY_DEPTH - 1);
  localparam logic [AW:0] FILL_MAX = (AW + 1)'(DELAY_DEPTH);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MX2  = 4'd1;
  localparam logic [3:0] ST_MC   = 4'd2;
  localparam logic [3:0] ST_MB   = 4'd3;
  localparam logic [3:0] ST_MA   = 4'd4;
  localparam logic [3:0] ST_MD   = 4'd5;
  localparam logic [3:0] ST_RD   = 4'd6;
  localparam logic [3:0] ST_MG   = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]          state, state_next;
  logic [GAIN_W-1:0]   gain;
  logic [DLY_W-1:0]    mean;
  logic [DLY_W-1:0]    depth;
  logic [STEP_W-1:0]   step;
  logic [PHASE_W-1:0]  phase;
  logic [AW-1:0]       wi;
  logic [AW:0]         fill;
  logic signed [SAMPLE_W-1:0] x_smp;
  logic [MUL_W-1:0]    x2;
  logic                hit;

  logic                accept, out_free, load;
  mul_req_t            req;
  logic signed [PROD_W-1:0] prod;
  logic [PHASE_W-1:0]  f;
  logic [30:0]         r;
  logic [15:0]         xs;
  logic [15:0]         s_mag;
  logic signed [15:0]  s;
  logic signed [36:0]  d;
  logic [AW-1:0]       delay, rd;
  logic [SAMPLE_W-1:0] rdata;
  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [36:0]  acc, acc_r;
  logic signed [21:0]  y;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign load      = (accept && channel) || (state == ST_FIN && out_free);

  // sine value at the quantized phase, quadrant-mirrored to q15
  always_comb begin
    f = phase & PHASE_MASK;
    r = phase[31:30] == 2'b00 || phase[31:30] == 2'b10 ? {1'b0, f[29:0]}
                                                        : 31'h4000_0000 - {1'b0, f[29:0]};
    xs = r[30:15];
    s_mag = (prod[PROD_W-1:15] > 21'sd32767) ? 16'd32767 : prod[30:15];
    s = phase[31] ? -$signed(s_mag) : $signed(s_mag);
  end

  // delay from mean plus depth * sine, clamped to the line
  always_comb begin
    d = $signed({10'd0, mean, 15'd0}) + 37'(prod);
    if (d[36]) begin
      delay = '0;
    end else if (d[36:15] > DMAX) begin
      delay = DMAX[AW-1:0];
    end else begin
      delay = d[AW+14:15];
    end
    rd = wi - delay;
  end

  assign delayed = hit ? $signed(rdata) : '0;

  // output: truncate toward zero, then saturate
  always_comb begin
    acc   = $signed({{6{x_smp[SAMPLE_W-1]}}, x_smp, 15'd0}) + 37'(prod);
    acc_r = acc[36] ? acc + 37'sd32767 : acc;
    y     = acc_r[36:15];
    if (y > 22'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y < -22'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y[15:0];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    req = '0;
    unique case (state)
      ST_MX2: begin
        req = '{en: 1'b1, a: {2'b0, xs}, b: {2'b0, xs}};
      end
      ST_MC: begin
        req = '{en: 1'b1, a: SIN_C, b: prod[32:15]};
      end
      ST_MB: begin
        req = '{en: 1'b1, a: SIN_B - prod[32:15], b: x2};
      end
      ST_MA: begin
        req = '{en: 1'b1, a: SIN_A - prod[32:15], b: {2'b0, xs}};
      end
      ST_MD: begin
        req = '{en: 1'b1, a: {6'd0, depth}, b: 18'(s)};
      end
      ST_MG: begin
        req = '{en: 1'b1, a: {3'd0, gain}, b: 18'(delayed)};
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && !channel) state_next = ST_MX2;
      ST_MX2:  state_next = ST_MC;
      ST_MC:   state_next = ST_MB;
      ST_MB:   state_next = ST_MA;
      ST_MA:   state_next = ST_MD;
      ST_MD:   state_next = ST_RD;
      ST_RD:   state_next = ST_MG;
      ST_MG:   state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gain      <= GAIN_RST;
      mean      <= MEAN_RST;
      depth     <= DEPTH_RST;
      step      <= STEP_RST;
      phase     <= '0;
      wi        <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GAIN:  gain  <= cfg_data[GAIN_W-1:0];
          REG_MEAN:  mean  <= cfg_data[DLY_W-1:0];
          REG_DEPTH: depth <= cfg_data[DLY_W-1:0];
          REG_STEP:  step  <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (accept && !channel) begin
        phase <= phase + step;
        wi    <= wi + 1'b1;
        if (fill != FILL_MAX) begin
          fill <= fill + 1'b1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_smp <= sample_in;
    end
    if (state == ST_MC) begin
      x2 <= prod[32:15];
    end
    if (state == ST_RD) begin
      // entries at or past the fill count were never written
      hit <= {1'b0, rd} < fill;
    end
    if (load) begin
      sample_out <= (accept && channel) ? sample_in : y_sat;
    end
  end

  af_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DELAY_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (accept && !channel),
    .waddr(wi),
    .wdata(sample_in),
    .raddr(rd),
    .rdata(rdata)
  );

  af_mul u_mul (
    .clk (clk),
    .req (req),
    .prod(prod)
  );

endmodule

`default_nettype wire

FILE: design/af_checker.sv
// ----------------------------------------------------------------------------
// af_checker
// port-level checks on the flanger, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_flanger_defines.svh"

module af_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [af_pkg::SAMPLE_W-1:0]   sample_in,
  input wire logic                          channel,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [af_pkg::SAMPLE_W-1:0]   sample_out
);

  import af_pkg::*;

  logic pass_acc, left_acc, held;

  assign pass_acc = !rst && in_valid && !in_stall && channel;
  assign left_acc = !rst && in_valid && !in_stall && !channel;
  assign held     = !rst && out_valid && out_stall;

  // a right word shows up unchanged on the next edge
  `AF_CHECK_NEXT(a_pass_through, pass_acc, out_valid && sample_out == $past(sample_in))

  // a left word keeps the block busy afterwards
  `AF_CHECK_NEXT(a_left_busy, left_acc, in_stall)

  `AF_CHECK_NEXT(a_out_keeps_valid, held, out_valid)

  `AF_CHECK_HOLD(a_out_keeps_word, held, sample_out)

endmodule

bind audio_flanger af_checker u_af_checker (.*);

`default_nettype wire

FILE: test/audio_flanger_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_flanger_test
// self-checking bench for the flanger: a predictor tracks the delay line, lfo
// phase and registers, and every output word is compared in order against it;
// directed corner words come first, then random chunks under changing settings
// ----------------------------------------------------------------------------

module audio_flanger_test;
  import af_pkg::*;

  localparam int LINE_LEN    = DELAY_DEPTH_DEF;
  localparam int SINE_SIZE   = SINE_SIZE_DEF;
  localparam int HOLD_AT     = 130;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 16;
  localparam int RUN_LIMIT   = 500000;
  localparam int CHUNKS      = 8;
  localparam int CHUNK_WORDS = 50;

  localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 4'd4;
  localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

  // sine polynomial, q15
  localparam longint unsigned POLY_A = 51472;
  localparam longint unsigned POLY_B = 21167;
  localparam longint unsigned POLY_C = 2611;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       ch;
  } flange_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic channel = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  audio_flanger uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .channel(channel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state and registers
  logic signed [SAMPLE_W-1:0] line_mem [LINE_LEN];
  logic [DLY_W-1:0]   line_wr;
  logic [PHASE_W-1:0] lfo_acc;
  logic [GAIN_W-1:0]  gain_reg;
  logic [DLY_W-1:0]   mean_reg;
  logic [DLY_W-1:0]   swing_reg;
  logic [STEP_W-1:0]  step_reg;

  flange_word_t pending_words[$];
  logic signed [SAMPLE_W-1:0] expected_out[$];

  int queued_total = 0;
  int in_count = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int send_wait = 0;
  int stall_wait = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;
  flange_word_t next_word;
  logic signed [SAMPLE_W-1:0] want;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int lfo_sine(input longint unsigned k);
    longint unsigned f, q, r, x, x2, p, s;
    f = (k << 32) / SINE_SIZE;
    q = f >> 30;
    r = f & 64'h3FFF_FFFF;
    if (q[0]) r = 64'h4000_0000 - r;
    x = r >> 15;
    x2 = (x * x) >> 15;
    p = (POLY_C * x2) >> 15;
    p = POLY_B - p;
    p = (p * x2) >> 15;
    p = POLY_A - p;
    s = (p * x) >> 15;
    if (s > 32767) s = 32767;
    return q[1] ? -int'(s) : int'(s);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] flange_word(
    input logic signed [SAMPLE_W-1:0] x,
    input logic ch
  );
    longint unsigned k;
    int s;
    longint d, acc, y;
    logic [DLY_W-1:0] dly, rd;
    if (ch) return x;
    line_mem[line_wr] = x;
    line_wr = line_wr + 1'b1;
    lfo_acc = lfo_acc + step_reg;
    k = (longint'(lfo_acc) * SINE_SIZE) >> 32;
    s = lfo_sine(k);
    d = longint'(mean_reg) * 32768 + longint'(swing_reg) * longint'(s);
    if (d < 0) dly = '0;
    else if ((d >>> 15) > LINE_LEN - 1) dly = LINE_LEN - 1;
    else dly = DLY_W'(d >>> 15);
    // zero delay wraps onto the oldest sample in the line
    rd = line_wr - dly;
    acc = longint'(x) * 32768 + longint'(gain_reg) * longint'(line_mem[rd]);
    y = (acc >= 0) ? (acc >>> 15) : -((-acc) >>> 15);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return SAMPLE_W'(y);
  endfunction

  function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
    case (idx)
      REG_GAIN:  gain_reg  = v[GAIN_W-1:0];
      REG_MEAN:  mean_reg  = v[DLY_W-1:0];
      REG_DEPTH: swing_reg = v[DLY_W-1:0];
      REG_STEP:  step_reg  = v[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return v[SAMPLE_W-1:0];
    endcase
  endfunction

  task automatic add_word(input logic signed [SAMPLE_W-1:0] smp, input logic ch);
    flange_word_t w;
    w.smp = smp;
    w.ch = ch;
    pending_words.push_back(w);
    queued_total++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, v);
    // cfg_valid goes low between writes
    @(posedge clk);
  endtask

  // sender stays quiet until every word is back, then the block is left to settle
  task automatic drain_block();
    do @(posedge clk); while (in_count != queued_total || expected_out.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic shuffle_regs();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 32767;
      default: v = $urandom();
    endcase
    write_reg(REG_GAIN, v);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 4095;
      default: v = $urandom_range(0, 400);
    endcase
    write_reg(REG_MEAN, v);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 4095;
      default: v = $urandom_range(0, 400);
    endcase
    write_reg(REG_DEPTH, v);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 32'hFFFF_FFFF;
      2, 3: v = $urandom_range(1, 200000);
      default: v = $urandom();
    endcase
    write_reg(REG_STEP, v);
    if ($urandom_range(0, 3) == 0)
      write_reg(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_count <= 0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_out.push_back(flange_word(sample_in, channel));
        in_count <= in_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          in_valid  <= 1'b1;
          sample_in <= next_word.smp;
          channel   <= next_word.ch;
          send_wait = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering words
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && in_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          $display("%0t: sample_out %0d with no word expected", $time, sample_out);
          fail_count++;
        end else begin
          want = expected_out.pop_front();
          if (sample_out !== want) begin
            $display("%0t: sample_out expected %0d got %0d", $time, want, sample_out);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (stall_wait > 0) begin
        stall_wait--;
        out_stall <= 1'b1;
      end else begin
        n = gap_len();
        out_stall <= (n > 0);
        stall_wait = (n > 0) ? n - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < LINE_LEN; i++) line_mem[i] = '0;
    line_wr   = '0;
    lfo_acc   = '0;
    gain_reg  = GAIN_RST;
    mean_reg  = MEAN_RST;
    swing_reg = DEPTH_RST;
    step_reg  = STEP_RST;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings, field extremes on both channels
    add_word(16'sd0, 1'b0);
    add_word(16'sh7FFF, 1'b1);
    add_word(16'sh8000, 1'b1);
    add_word(16'sd0, 1'b1);
    add_word(16'sh7FFF, 1'b0);
    add_word(16'sh8000, 1'b0);
    add_word(16'sd1, 1'b0);
    add_word(-16'sd1, 1'b0);
    drain_block();

    // full gain on the current word: saturation both ways, oversized data masked
    write_reg(REG_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_MEAN, 32'hABCD_E001);
    write_reg(REG_DEPTH, 32'd0);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    repeat (3) add_word(16'sh7FFF, 1'b0);
    repeat (3) add_word(16'sh8000, 1'b0);
    drain_block();

    // zero delay with a frozen lfo
    write_reg(REG_MEAN, 32'd0);
    write_reg(REG_STEP, 32'd0);
    add_word(16'sd12345, 1'b0);
    add_word(-16'sd2222, 1'b0);
    add_word(16'sd5, 1'b1);
    drain_block();

    // delay past the end of the line, writes to unused indexes dropped
    write_reg(REG_GAIN, 32'd16384);
    write_reg(REG_MEAN, 32'd4095);
    write_reg(REG_DEPTH, 32'd4095);
    write_reg(REG_STEP, 32'h4000_0000);
    write_reg(REG_SPARE_FIRST, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_LAST, 32'h0);
    repeat (4) add_word(rand_sample(), 1'b0);
    drain_block();

    // zero mean with the lfo at zero gives zero delay, zero gain
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_MEAN, 32'd0);
    write_reg(REG_STEP, 32'h8000_0000);
    repeat (3) add_word(rand_sample(), 1'b0);
    drain_block();

    for (int c = 0; c < CHUNKS; c++) begin
      if (c == 0 || $urandom_range(0, 2) != 0) shuffle_regs();
      calm = (c % 3 == 1);
      for (int i = 0; i < CHUNK_WORDS; i++)
        add_word(rand_sample(), ($urandom_range(0, 9) < 3));
      drain_block();
    end

    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
